// ===== rtl/fsk_half_period_bit_decoder_top_macros.svh =====
// Assertion macros for the FSK half-period bit decoder.
// Used by the RTL files that carry concurrent assertions; depends on nothing.
`ifndef FSK_HALF_PERIOD_BIT_DECODER_TOP_MACROS_SVH
`define FSK_HALF_PERIOD_BIT_DECODER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FSK_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define FSK_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) pre |=> post) else $error(msg);
`else
`define FSK_ASSERT(label, prop, msg)
`define FSK_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ===== rtl/fsk_hp_pkg.sv =====
// Shared types and constants for the FSK half-period bit decoder.
// Used by the serial divider and the top level; depends on nothing.
package fsk_hp_pkg;

   localparam int CFG_W  = 24;
   localparam int COST_W = 24;
   localparam int FRAC_W = 16;

   localparam logic [COST_W-1:0] COST_INF = {COST_W{1'b1}};

   localparam logic [1:0] KIND_ZERO    = 2'd0;
   localparam logic [1:0] KIND_ONE     = 2'd1;
   localparam logic [1:0] KIND_UNKNOWN = 2'd2;

   localparam logic [1:0] REG_SHORT_PERIOD = 2'd0;
   localparam logic [1:0] REG_LONG_PERIOD  = 2'd1;
   localparam logic [1:0] REG_MAX_ERROR    = 2'd2;

   typedef struct packed {
      logic              done;
      logic [COST_W-1:0] quotient;
   } div_status_type;

endpackage

// ===== rtl/fsk_hp_div.sv =====
// Bit-serial restoring divider computing floor(dividend * 2^16 / divisor), saturated.
// Depends on fsk_hp_pkg.
module fsk_hp_div #(
   parameter int DIV_W = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [DIV_W-1:0]           dividend,
   input  logic [DIV_W-1:0]           divisor,
   output fsk_hp_pkg::div_status_type status
);

   localparam int STEPS = DIV_W + fsk_hp_pkg::FRAC_W;
   localparam int CNT_W = $clog2(STEPS);

   logic                          busy_ff;
   logic                          done_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic [DIV_W:0]                rem_ff;
   logic [STEPS-1:0]              num_ff;
   logic [DIV_W-1:0]              div_ff;
   logic [fsk_hp_pkg::COST_W-1:0] q_ff;
   logic                          ovf_ff;

   logic [DIV_W:0] rem_shift;
   logic           fits;
   logic [DIV_W:0] rem_in;

   assign rem_shift = {rem_ff[DIV_W-1:0], num_ff[STEPS-1]};
   assign fits      = rem_shift >= {1'b0, div_ff};
   assign rem_in    = fits ? rem_shift - {1'b0, div_ff} : rem_shift;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= {dividend, {fsk_hp_pkg::FRAC_W{1'b0}}};
         div_ff <= divisor;
         rem_ff <= '0;
         q_ff   <= '0;
         ovf_ff <= 1'b0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[STEPS-2:0], 1'b0};
         rem_ff <= rem_in;
         q_ff   <= {q_ff[fsk_hp_pkg::COST_W-2:0], fits};
         ovf_ff <= ovf_ff | q_ff[fsk_hp_pkg::COST_W-1];
      end
   end

   assign status.done     = done_ff;
   assign status.quotient = ovf_ff ? fsk_hp_pkg::COST_INF : q_ff;

endmodule

// ===== rtl/fsk_half_period_bit_decoder_top.sv =====
// FSK half-period bit decoder: four-entry interval window scored as zero, one or unknown bits.
// Depends on fsk_hp_pkg, fsk_hp_div and fsk_half_period_bit_decoder_top_macros.svh.
//
// Each interval goes through one serial divider, one quotient bit per cycle, which computes
// the long and then the short relative error of the interval. A decision follows once the
// window holds four entries or the interval ends the stream; such an interval gives one
// result per decision of its flush (up to four), and a decision waits until the result
// register is free. The block is not ready while an interval is being worked on; a result
// waiting on rsp_valid does not hold up the next transfer unless a further decision needs
// the result register.
`include "fsk_half_period_bit_decoder_top_macros.svh"
module fsk_half_period_bit_decoder_top #(
   parameter int TICK_WIDTH     = 48,
   parameter int DURATION_WIDTH = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [TICK_WIDTH-1:0]     req_edge_tick,
   input  logic [DURATION_WIDTH-1:0] req_delta,
   input  logic                      req_end_of_stream,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_kind,
   output logic [TICK_WIDTH-1:0]     rsp_start_tick,
   output logic [TICK_WIDTH-1:0]     rsp_end_tick,
   output logic [23:0]               rsp_cost,
   output logic                      rsp_last_of_flush,
   input  logic                      csr_write_enable,
   input  logic [1:0]                csr_index,
   input  logic [23:0]               csr_write_data
);

   localparam int CW    = fsk_hp_pkg::COST_W;
   localparam int DIV_W = (DURATION_WIDTH > fsk_hp_pkg::CFG_W) ? DURATION_WIDTH
                                                                : fsk_hp_pkg::CFG_W;
   localparam int SUM_W = DURATION_WIDTH + 2;
   localparam int END_W = (TICK_WIDTH > SUM_W) ? TICK_WIDTH : SUM_W;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DIVL   = 2'd1;
   localparam logic [1:0] S_DIVS   = 2'd2;
   localparam logic [1:0] S_DECIDE = 2'd3;

   logic [1:0]  state_ff;
   logic [2:0]  fill_ff;
   logic        eos_ff;
   logic        rsp_valid_ff;
   logic [23:0] short_ff;
   logic [23:0] long_ff;
   logic [23:0] max_ff;

   logic [TICK_WIDTH-1:0]     tick_ff;
   logic [DURATION_WIDTH-1:0] dlt_ff;
   logic [CW-1:0]             lerr_hold_ff;

   logic [DURATION_WIDTH-1:0] dur_ff  [4];
   logic [TICK_WIDTH-1:0]     edge_ff [4];
   logic [CW-1:0]             lerr_ff [4];
   logic [CW-1:0]             serr_ff [4];

   logic [1:0]            kind_ff;
   logic [TICK_WIDTH-1:0] start_ff;
   logic [TICK_WIDTH-1:0] end_ff;
   logic [CW-1:0]         cost_ff;
   logic                  last_ff;

   logic                       req_xfer;
   logic                       div_start;
   logic [DIV_W-1:0]           meas;
   logic [DIV_W-1:0]           target;
   logic [DIV_W-1:0]           diff;
   fsk_hp_pkg::div_status_type div_stat;

   logic [CW:0]       zsum;
   logic [CW+1:0]     osum;
   logic [CW-1:0]     score_zero;
   logic [CW-1:0]     score_one;
   logic              zero_ok;
   logic              one_ok;
   logic [1:0]        kind_in;
   logic [2:0]        used_in;
   logic [CW-1:0]     cost_in;
   logic [SUM_W-1:0]  dsum;
   logic [END_W-1:0]  end_full;
   logic [2:0]        fill_left;
   logic              out_free;
   logic              load_rsp;
   logic              flush_end;
   logic              drained;
   logic              in_divide;

   assign req_ready = state_ff == S_IDLE;
   assign req_xfer  = req_valid && req_ready;
   assign div_start = req_xfer || (state_ff == S_DIVL && div_stat.done);

   assign meas   = (state_ff == S_IDLE) ? DIV_W'(req_delta) : DIV_W'(dlt_ff);
   assign target = (state_ff == S_IDLE) ? DIV_W'(long_ff) : DIV_W'(short_ff);
   assign diff   = (meas > target) ? meas - target : target - meas;

   fsk_hp_div #(
      .DIV_W(DIV_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(diff),
      .divisor (target),
      .status  (div_stat)
   );

   always_comb begin
      zsum       = {1'b0, lerr_ff[0]} + {1'b0, lerr_ff[1]};
      osum       = (CW+2)'(serr_ff[0]) + (CW+2)'(serr_ff[1])
                 + (CW+2)'(serr_ff[2]) + (CW+2)'(serr_ff[3]);
      score_zero = (fill_ff >= 3'd2) ? zsum[CW:1] : fsk_hp_pkg::COST_INF;
      score_one  = (fill_ff >= 3'd4) ? osum[CW+1:2] : fsk_hp_pkg::COST_INF;
      zero_ok    = score_zero != fsk_hp_pkg::COST_INF && score_zero <= score_one
                   && score_zero <= max_ff;
      one_ok     = score_one != fsk_hp_pkg::COST_INF && score_one < score_zero
                   && score_one <= max_ff;
      if (zero_ok) begin
         kind_in = fsk_hp_pkg::KIND_ZERO;
         used_in = 3'd2;
         cost_in = score_zero;
      end else if (one_ok) begin
         kind_in = fsk_hp_pkg::KIND_ONE;
         used_in = 3'd4;
         cost_in = score_one;
      end else begin
         kind_in = fsk_hp_pkg::KIND_UNKNOWN;
         used_in = 3'd1;
         cost_in = (score_zero <= score_one) ? score_zero : score_one;
      end
      dsum = SUM_W'(dur_ff[0]);
      if (used_in >= 3'd2) begin
         dsum = dsum + SUM_W'(dur_ff[1]);
      end
      if (used_in == 3'd4) begin
         dsum = dsum + SUM_W'(dur_ff[2]) + SUM_W'(dur_ff[3]);
      end
      end_full  = END_W'(edge_ff[0]) + END_W'(dsum);
      fill_left = fill_ff - used_in;
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load_rsp  = state_ff == S_DECIDE && out_free;
   assign flush_end = load_rsp && eos_ff && fill_left == 3'd0;
   assign drained   = fill_ff == 3'd0 && state_ff == S_IDLE;
   assign in_divide = state_ff == S_DIVL || state_ff == S_DIVS;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         short_ff     <= 24'd52;
         long_ff      <= 24'd104;
         max_ff       <= 24'd22938;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               fsk_hp_pkg::REG_SHORT_PERIOD: short_ff <= csr_write_data;
               fsk_hp_pkg::REG_LONG_PERIOD:  long_ff  <= csr_write_data;
               fsk_hp_pkg::REG_MAX_ERROR:    max_ff   <= csr_write_data;
               default: ;
            endcase
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  state_ff <= S_DIVL;
               end
            end
            S_DIVL: begin
               if (div_stat.done) begin
                  state_ff <= S_DIVS;
               end
            end
            S_DIVS: begin
               if (div_stat.done) begin
                  fill_ff  <= fill_ff + 3'd1;
                  state_ff <= (eos_ff || fill_ff == 3'd3) ? S_DECIDE : S_IDLE;
               end
            end
            S_DECIDE: begin
               if (out_free) begin
                  fill_ff <= fill_left;
                  if (!(eos_ff && fill_left != 3'd0)) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         tick_ff <= req_edge_tick;
         dlt_ff  <= req_delta;
         eos_ff  <= req_end_of_stream;
      end
      if (state_ff == S_DIVL && div_stat.done) begin
         lerr_hold_ff <= div_stat.quotient;
      end
      if (state_ff == S_DIVS && div_stat.done) begin
         dur_ff[fill_ff[1:0]]  <= dlt_ff;
         edge_ff[fill_ff[1:0]] <= tick_ff;
         lerr_ff[fill_ff[1:0]] <= lerr_hold_ff;
         serr_ff[fill_ff[1:0]] <= div_stat.quotient;
      end
      if (load_rsp) begin
         kind_ff  <= kind_in;
         start_ff <= edge_ff[0];
         end_ff   <= end_full[TICK_WIDTH-1:0];
         cost_ff  <= cost_in;
         last_ff  <= eos_ff && fill_left == 3'd0;
         case (used_in)
            3'd1: begin
               for (int i = 0; i < 3; i++) begin
                  dur_ff[i]  <= dur_ff[i+1];
                  edge_ff[i] <= edge_ff[i+1];
                  lerr_ff[i] <= lerr_ff[i+1];
                  serr_ff[i] <= serr_ff[i+1];
               end
            end
            3'd2: begin
               for (int i = 0; i < 2; i++) begin
                  dur_ff[i]  <= dur_ff[i+2];
                  edge_ff[i] <= edge_ff[i+2];
                  lerr_ff[i] <= lerr_ff[i+2];
                  serr_ff[i] <= serr_ff[i+2];
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_start_tick    = start_ff;
   assign rsp_end_tick      = end_ff;
   assign rsp_cost          = cost_ff;
   assign rsp_last_of_flush = last_ff;

   `FSK_ASSERT(a_fill_bound, fill_ff <= 3'd4, "window fill above four")
   `FSK_ASSERT(a_decide_nonempty, state_ff != S_DECIDE || fill_ff != 3'd0, "empty decision")
   `FSK_ASSERT_NEXT(a_flush_empties, flush_end, drained, "flush left entries")
   `FSK_ASSERT(a_div_done_state, !div_stat.done || in_divide, "divider done outside a divide")

endmodule

// ===== verif/fsk_half_period_bit_decoder_top_tb.sv =====
// Self-checking testbench for the FSK half-period bit decoder top level.
// Depends on fsk_hp_pkg and fsk_half_period_bit_decoder_top; a built-in predictor checks
// every result transfer while both channels idle and stall at random.
module fsk_half_period_bit_decoder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [47:0] tick;
      logic [23:0] delta;
      logic        eos;
   } interval_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [47:0] first_tick;
      logic [47:0] stop_tick;
      logic [23:0] cost;
      logic        last;
   } symbol_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 120;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [47:0] req_edge_tick = '0;
   logic [23:0] req_delta = '0;
   logic        req_end_of_stream = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [47:0] rsp_start_tick;
   logic [47:0] rsp_end_tick;
   logic [23:0] rsp_cost;
   logic        rsp_last_of_flush;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [23:0] csr_write_data = '0;

   fsk_half_period_bit_decoder_top u_top (.*);

   interval_type pending_intervals[$];
   symbol_type   expected_symbols[$];
   logic [23:0] win_dur[4];
   logic [47:0] win_tick[4];
   logic [23:0] win_lerr[4];
   logic [23:0] win_serr[4];
   int          win_fill;
   logic [23:0] short_per, long_per, max_err;
   int          mismatches = 0;
   int          idle_cycles = 0;
   bit          req_fire = 1'b0;
   bit          quiet = 1'b0;
   bit          long_hold_go = 1'b0;
   bit          long_hold_done = 1'b0;
   int          send_gap = 0;
   int          recv_hold = 0;
   logic [47:0] next_tick = 48'd1000;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [23:0] rel_err(logic [23:0] meas, logic [23:0] target);
      logic [63:0] diff, q;
      if (target == 0) return fsk_hp_pkg::COST_INF;
      diff = (meas > target) ? 64'(meas - target) : 64'(target - meas);
      q = (diff << 16) / 64'(target);
      return (q > 64'hFFFFFF) ? fsk_hp_pkg::COST_INF : q[23:0];
   endfunction

   task automatic decide_symbol();
      logic [25:0] acc;
      logic [23:0] zc, oc;
      symbol_type  s;
      int          used;
      zc = fsk_hp_pkg::COST_INF;
      oc = fsk_hp_pkg::COST_INF;
      if (win_fill >= 2) begin
         acc = 26'(win_lerr[0]) + 26'(win_lerr[1]);
         zc = 24'(acc >> 1);
      end
      if (win_fill >= 4) begin
         acc = 26'(win_serr[0]) + 26'(win_serr[1]) + 26'(win_serr[2]) + 26'(win_serr[3]);
         oc = 24'(acc >> 2);
      end
      if (zc != fsk_hp_pkg::COST_INF && zc <= oc && zc <= max_err) begin
         s.kind = fsk_hp_pkg::KIND_ZERO; used = 2; s.cost = zc;
      end else if (oc != fsk_hp_pkg::COST_INF && oc < zc && oc <= max_err) begin
         s.kind = fsk_hp_pkg::KIND_ONE; used = 4; s.cost = oc;
      end else begin
         s.kind = fsk_hp_pkg::KIND_UNKNOWN; used = 1; s.cost = (zc <= oc) ? zc : oc;
      end
      s.first_tick = win_tick[0];
      s.stop_tick = win_tick[0];
      for (int i = 0; i < used; i++) s.stop_tick += 48'(win_dur[i]);
      s.last = 1'b0;
      expected_symbols.push_back(s);
      if (used > win_fill) used = win_fill;
      for (int i = 0; i + used < win_fill; i++) begin
         win_dur[i]  = win_dur[i + used];
         win_tick[i] = win_tick[i + used];
         win_lerr[i] = win_lerr[i + used];
         win_serr[i] = win_serr[i + used];
      end
      win_fill -= used;
   endtask

   task automatic predict_interval(interval_type it);
      int         n;
      bit         was_last;
      symbol_type s;
      n = 0;
      if (win_fill >= 4) begin
         decide_symbol();
         n++;
      end
      win_dur[win_fill & 3]  = it.delta;
      win_tick[win_fill & 3] = it.tick;
      win_lerr[win_fill & 3] = rel_err(it.delta, long_per);
      win_serr[win_fill & 3] = rel_err(it.delta, short_per);
      win_fill++;
      if (it.eos) begin
         while (win_fill > 0 && n < 4) begin
            was_last = (win_fill == 1);
            decide_symbol();
            n++;
            if (win_fill == 0 || was_last) begin
               s = expected_symbols.pop_back();
               s.last = 1'b1;
               expected_symbols.push_back(s);
            end
         end
         win_fill = 0;
      end else if (win_fill >= 4) begin
         decide_symbol();
      end
   endtask

   // Predictor, checker and watchdog, all sampled at the rising edge.
   always @(posedge clock) begin
      symbol_type got, exp_s;
      req_fire = req_valid && req_ready && !reset;
      if (reset) begin
         win_fill  = 0;
         short_per = 24'd52;
         long_per  = 24'd104;
         max_err   = 24'd22938;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               fsk_hp_pkg::REG_SHORT_PERIOD: short_per = csr_write_data;
               fsk_hp_pkg::REG_LONG_PERIOD:  long_per  = csr_write_data;
               fsk_hp_pkg::REG_MAX_ERROR:    max_err   = csr_write_data;
               default: ;
            endcase
         end
         if (req_fire) predict_interval('{req_edge_tick, req_delta, req_end_of_stream});
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_kind, rsp_start_tick, rsp_end_tick, rsp_cost, rsp_last_of_flush};
            if (expected_symbols.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result transfer: %p", got);
            end else begin
               exp_s = expected_symbols.pop_front();
               if (got !== exp_s) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p", exp_s, got);
               end
            end
         end
         if (req_fire || (rsp_valid && rsp_ready) || csr_write_enable) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("** fsk_half_period_bit_decoder_top: FAILED **");
            $finish;
         end
      end
   end

   // Sender: holds an offered interval until its transfer.
   always @(negedge clock) begin
      interval_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
      end else if (send_gap > 0) begin
         send_gap--;
         req_valid <= 1'b0;
      end else if (pending_intervals.size() != 0 && !quiet && $urandom_range(0, 5) == 0) begin
         send_gap = $urandom_range(1, 13) - 1;
         req_valid <= 1'b0;
      end else if (pending_intervals.size() != 0) begin
         it = pending_intervals.pop_front();
         req_valid         <= 1'b1;
         req_edge_tick     <= it.tick;
         req_delta         <= it.delta;
         req_end_of_stream <= it.eos;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: random stall bursts plus one long hold-off on request.
   always @(negedge clock) begin
      if (long_hold_go && !long_hold_done) begin
         long_hold_done = 1'b1;
         recv_hold = 700;
      end
      if (recv_hold > 0) begin
         recv_hold--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         recv_hold = $urandom_range(1, 13) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic push_interval(logic [23:0] d, logic e);
      pending_intervals.push_back('{next_tick, d, e});
      next_tick += 48'(d);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [23:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic settle();
      while (pending_intervals.size() != 0 || req_valid || expected_symbols.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [23:0] jitter(logic [23:0] base);
      int span;
      span = int'(base >> 3) + 1;
      return 24'(int'(base) + $urandom_range(0, 2 * span) - span);
   endfunction

   task automatic add_random(int count);
      int sel;
      for (int i = 0; i < count; ) begin
         sel = $urandom_range(0, 99);
         if ($urandom_range(0, 19) == 0) next_tick = 48'({$urandom(), $urandom()});
         if (sel < 40) begin
            push_interval(jitter(long_per), 1'b0);
            push_interval(jitter(long_per), 1'b0);
            i += 2;
         end else if (sel < 75) begin
            for (int k = 0; k < 4; k++) push_interval(jitter(short_per), 1'b0);
            i += 4;
         end else if (sel < 90) begin
            push_interval(24'($urandom()), 1'b0);
            i++;
         end else begin
            push_interval($urandom_range(0, 1) ? jitter(short_per) : 24'($urandom()), 1'b1);
            i++;
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: clean bits, extreme deltas, tick wrap, flushes of one and of four entries.
      push_interval(24'd104, 1'b0);
      push_interval(24'd104, 1'b0);
      for (int k = 0; k < 4; k++) push_interval(24'd52, 1'b0);
      push_interval(24'd0, 1'b0);
      push_interval(24'hFFFFFF, 1'b0);
      push_interval(24'd78, 1'b0);
      push_interval(24'd104, 1'b1);
      push_interval(24'd52, 1'b1);
      next_tick = 48'hFFFF_FFFF_FF00;
      push_interval(24'd104, 1'b0);
      push_interval(24'd104, 1'b0);
      push_interval(24'd52, 1'b0);
      push_interval(24'd52, 1'b1);
      for (int k = 0; k < 4; k++) push_interval(24'd60, k == 3);
      settle();

      write_reg(fsk_hp_pkg::REG_SHORT_PERIOD, 24'd0);
      write_reg(fsk_hp_pkg::REG_MAX_ERROR, 24'hFFFFFF);
      for (int k = 0; k < 5; k++) push_interval(24'd52, k == 4);
      settle();

      write_reg(fsk_hp_pkg::REG_SHORT_PERIOD, 24'd1);
      write_reg(fsk_hp_pkg::REG_LONG_PERIOD, 24'hFFFFFF);
      write_reg(REG_UNUSED, 24'h123456);
      push_interval(24'hFFFFFF, 1'b0);
      push_interval(24'hFFFFFF, 1'b0);
      push_interval(24'd1, 1'b0);
      push_interval(24'd0, 1'b1);
      settle();

      write_reg(fsk_hp_pkg::REG_LONG_PERIOD, 24'd0);
      write_reg(fsk_hp_pkg::REG_MAX_ERROR, 24'd0);
      for (int k = 0; k < 5; k++) push_interval(24'd1, k == 4);
      settle();

      write_reg(fsk_hp_pkg::REG_SHORT_PERIOD, 24'd40);
      write_reg(fsk_hp_pkg::REG_LONG_PERIOD, 24'd80);
      write_reg(fsk_hp_pkg::REG_MAX_ERROR, 24'd30000);
      add_random(45);
      long_hold_go = 1'b1;
      add_random(20);
      settle();

      add_random(50);
      settle();
      write_reg(fsk_hp_pkg::REG_MAX_ERROR, 24'd8000);
      quiet = 1'b1;
      add_random(30);
      push_interval(24'd80, 1'b1);
      settle();

      if (mismatches == 0 && expected_symbols.size() == 0) begin
         $display("** fsk_half_period_bit_decoder_top: PASSED **");
      end else begin
         $display("** fsk_half_period_bit_decoder_top: FAILED **");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fsk_hp_pkg.sv
rtl/fsk_hp_div.sv
rtl/fsk_half_period_bit_decoder_top.sv
verif/fsk_half_period_bit_decoder_top_tb.sv
